[hw/rtl/egv_pkg.sv]
`default_nettype none
package egv_pkg;

	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 24;
	localparam int ACC_W   = 44;
	localparam int DEN_W   = ACC_W - 1;
	localparam int NUM_W   = 57;
	localparam int DIM_DEF = 3;

	localparam logic [2:0] OP_LOAD_F   = 3'd0;
	localparam logic [2:0] OP_LOAD_FP  = 3'd1;
	localparam logic [2:0] OP_LOAD_DFP = 3'd2;
	localparam logic [2:0] OP_COMPUTE  = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		logic clr;
		logic vld;
		logic sub;
	} mac_ctl_t;

	localparam data_t ONE_Q   = 32'sh0100_0000;
	localparam acc_t  SAT_MAX = acc_t'(64'sh0000_0000_7FFF_FFFF);
	localparam acc_t  SAT_MIN = acc_t'(-64'sh0000_0000_8000_0000);

	function automatic data_t sat32(input acc_t v);
		if (v > SAT_MAX) begin
			return data_t'(SAT_MAX[DATA_W-1:0]);
		end
		if (v < SAT_MIN) begin
			return data_t'(SAT_MIN[DATA_W-1:0]);
		end
		return data_t'(v[DATA_W-1:0]);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/egv_mac.sv]
`default_nettype none
module egv_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire egv_pkg::mac_ctl_t ctl,
	input  wire egv_pkg::data_t    a,
	input  wire egv_pkg::data_t    b,
	output egv_pkg::acc_t          acc
);

	logic signed [2*egv_pkg::DATA_W-1:0] prod_s1;
	logic signed [2*egv_pkg::DATA_W-1:0] rnd;
	logic                                vld_s1;
	logic                                sub_s1;
	egv_pkg::acc_t                       term;
	egv_pkg::acc_t                       acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		sub_s1  <= ctl.sub;
	end

	assign rnd  = (prod_s1 + (64'sd1 <<< (egv_pkg::FRAC_W - 1))) >>> egv_pkg::FRAC_W;
	assign term = egv_pkg::acc_t'(rnd[egv_pkg::ACC_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= sub_s1 ? acc_q - term : acc_q + term;
		end
	end

	assign acc = acc_q;

	a_clr_idle: assert property (@(posedge clk) disable iff (!arst_n) ctl.clr |-> !vld_s1)
		else $error("accumulator cleared with a product in flight");

endmodule
`default_nettype wire

[hw/rtl/egv_div.sv]
`default_nettype none
module egv_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [egv_pkg::NUM_W-1:0]   num,
	input  wire logic [egv_pkg::DEN_W-1:0]   den,
	output logic                             busy,
	output logic                             done,
	output logic [egv_pkg::NUM_W-1:0]        quot
);

	localparam int CNT_W = $clog2(egv_pkg::NUM_W + 1);

	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [egv_pkg::DEN_W:0]     rem_q;
	logic [egv_pkg::DEN_W:0]     rem_sh;
	logic [egv_pkg::NUM_W-1:0]   q_q;
	logic [egv_pkg::DEN_W-1:0]   den_q;
	logic                        fit;

	assign rem_sh = {rem_q[egv_pkg::DEN_W-1:0], q_q[egv_pkg::NUM_W-1]};
	assign fit    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(egv_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fit ? rem_sh - {1'b0, den_q} : rem_sh;
			q_q   <= {q_q[egv_pkg::NUM_W-2:0], fit};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = q_q;

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule
`default_nettype wire

[hw/rtl/elastic_gradient_variation_core.sv]
// Elastic gradient variation core.
// Input channel (in_valid/in_ready): one request per item, opcode selects
// load F, load Fp, load dFp, compute or read; element_index is row-major.
// Output channel (out_valid/out_ready): one result for compute and read.
// Loads are stored on acceptance and leave the sequencer idle; like every
// request they wait while a result is held in the output register.
// A read goes through the synchronous result memory, then fills the
// output register.
// A compute walks one shared multiplier (per product: latch operands,
// multiply, accumulate; per finished sum: store), then 9 quotients on a
// radix-2 divider of 57 steps.
// At DIM 3 that is cofactors, determinant, inverse, and then 9 columns
// of three 3x3 contractions.
// A singular plastic gradient ends the compute after the determinant.
// The output register holds its result while out_ready is low; no new
// request is taken until that register is free or being freed.
// Reset clears the sequencer, the output valid flag and the singular flag;
// stored tensors are undefined until loaded.
`default_nettype none
module elastic_gradient_variation_core #(
	parameter int DIM = egv_pkg::DIM_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        opcode,
	input  wire logic [6:0]        element_index,
	input  wire egv_pkg::data_t    data_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   result_kind,
	output egv_pkg::data_t         data_out,
	output logic                   singular
);

	localparam int MAT_N = DIM * DIM;
	localparam int TEN_N = MAT_N * MAT_N;
	localparam int MI_W  = $clog2(MAT_N);
	localparam int TI_W  = $clog2(TEN_N);
	localparam int CW    = $clog2(DIM);
	localparam int COF_LEN = (DIM == 3) ? 2 : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_COF  = 4'd1;
	localparam logic [3:0] S_DET  = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_T    = 4'd4;
	localparam logic [3:0] S_W    = 4'd5;
	localparam logic [3:0] S_E    = 4'd6;
	localparam logic [3:0] S_RESP = 4'd7;
	localparam logic [3:0] S_READ = 4'd8;

	function automatic logic [MI_W-1:0] mi(input int r, input int c);
		return MI_W'(r * DIM + c);
	endfunction

	egv_pkg::data_t f_q    [MAT_N];
	egv_pkg::data_t p_q    [MAT_N];
	egv_pkg::data_t cof_q  [MAT_N];
	egv_pkg::data_t pinv_q [MAT_N];
	egv_pkg::data_t t_q    [MAT_N];
	egv_pkg::data_t w_q    [MAT_N];
	egv_pkg::data_t dfp_mem [TEN_N];
	egv_pkg::data_t dfe_mem [TEN_N];

	logic [3:0]      state_q;
	logic [1:0]      sub_q;
	logic [CW-1:0]   r_q, c_q, n_q, l_q, m_q;
	logic            sing_q;
	logic            out_valid_q;
	logic            kind_q;
	egv_pkg::data_t  dout_q;
	logic            osing_q;
	logic            oob_q;
	egv_pkg::acc_t   det_q;
	egv_pkg::data_t  opa_q, opb_q;
	logic            osub_q;
	egv_pkg::data_t  dfp_rd_q, dfe_rd_q;

	egv_pkg::data_t   opa, opb;
	logic             osub;
	logic [TI_W-1:0]  dfp_raddr;
	logic [TI_W-1:0]  dfe_waddr;
	logic [TI_W-1:0]  dfe_raddr;
	logic             accept;
	logic             busy_ph;
	logic             fin;
	logic             n_last;
	logic             rc_last;
	logic             base_last;
	egv_pkg::acc_t    acc;
	egv_pkg::mac_ctl_t mac_ctl;
	egv_pkg::data_t   mac_b;
	egv_pkg::data_t   cof_sel;
	egv_pkg::data_t   e_val;
	egv_pkg::acc_t    ident;
	logic [31:0]      cmag;
	logic [egv_pkg::DEN_W-1:0] dmag;
	logic [egv_pkg::NUM_W-1:0] div_num;
	logic [egv_pkg::NUM_W-1:0] quot;
	logic             div_start, div_busy, div_done;
	logic             qneg, qbig;
	egv_pkg::data_t   pinv_val;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign busy_ph  = (state_q == S_COF) || (state_q == S_DET) || (state_q == S_T) ||
	                  (state_q == S_W) || (state_q == S_E);
	assign fin      = busy_ph && (sub_q == 2'd3);
	assign n_last   = (state_q == S_COF) ? (n_q == CW'(COF_LEN - 1)) : (n_q == CW'(DIM - 1));
	assign rc_last  = (r_q == CW'(DIM - 1)) && (c_q == CW'(DIM - 1));
	assign base_last = (l_q == CW'(DIM - 1)) && (m_q == CW'(DIM - 1));

	always_comb begin
		int ri, ci, ni, r1, r2, c1, c2;
		ri = int'(r_q);
		ci = int'(c_q);
		ni = int'(n_q);
		r1 = (ri == 0) ? 1 : 0;
		r2 = (ri == 2) ? 1 : 2;
		c1 = (ci == 0) ? 1 : 0;
		c2 = (ci == 2) ? 1 : 2;
		opa  = '0;
		opb  = '0;
		osub = 1'b0;
		case (state_q)
			S_COF: begin
				if (DIM == 3) begin
					if (n_q == '0) begin
						opa = p_q[mi(r1, c1)];
						opb = p_q[mi(r2, c2)];
					end else begin
						opa  = p_q[mi(r1, c2)];
						opb  = p_q[mi(r2, c1)];
						osub = 1'b1;
					end
				end else begin
					opa = p_q[mi(DIM - 1 - ri, DIM - 1 - ci)];
					opb = egv_pkg::ONE_Q;
				end
			end
			S_DET: begin
				opa = p_q[mi(0, ni)];
				opb = cof_q[mi(0, ni)];
			end
			S_T: begin
				opa = pinv_q[mi(ri, ni)];
			end
			S_W: begin
				opa = t_q[mi(ri, ni)];
				opb = pinv_q[mi(ni, ci)];
			end
			S_E: begin
				opa = f_q[mi(ri, ni)];
				opb = w_q[mi(ni, ci)];
			end
			default: begin
				opa = '0;
			end
		endcase
		dfp_raddr = TI_W'((ni * DIM + ci) * MAT_N + int'(l_q) * DIM + int'(m_q));
		dfe_waddr = TI_W'((ri * DIM + ci) * MAT_N + int'(l_q) * DIM + int'(m_q));
	end

	assign dfe_raddr = element_index[TI_W-1:0];

	assign mac_ctl.clr = fin;
	assign mac_ctl.vld = busy_ph && (sub_q == 2'd1);
	assign mac_ctl.sub = osub_q;
	assign mac_b       = (state_q == S_T) ? dfp_rd_q : opb_q;

	egv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (opa_q),
		.b      (mac_b),
		.acc    (acc)
	);

	assign cof_sel   = cof_q[mi(int'(c_q), int'(r_q))];
	assign cmag      = cof_sel[egv_pkg::DATA_W-1] ? 32'(-cof_sel) : 32'(cof_sel);
	assign dmag      = det_q[egv_pkg::ACC_W-1] ? egv_pkg::DEN_W'(-det_q)
	                                           : egv_pkg::DEN_W'(det_q);
	assign div_num   = (egv_pkg::NUM_W'(cmag) << egv_pkg::FRAC_W) +
	                   egv_pkg::NUM_W'(dmag >> 1);
	assign div_start = (state_q == S_DIV) && (sub_q == 2'd0);
	assign qneg      = cof_sel[egv_pkg::DATA_W-1] ^ det_q[egv_pkg::ACC_W-1];
	assign qbig      = |quot[egv_pkg::NUM_W-1:31];

	egv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dmag),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		if (qneg) begin
			pinv_val = qbig ? egv_pkg::data_t'(32'h8000_0000)
			                : egv_pkg::data_t'(32'd0 - quot[31:0]);
		end else begin
			pinv_val = qbig ? egv_pkg::data_t'(32'h7FFF_FFFF)
			                : egv_pkg::data_t'(quot[31:0]);
		end
	end

	assign ident = (r_q == l_q) ? egv_pkg::acc_t'(pinv_q[mi(int'(m_q), int'(c_q))]) : '0;
	assign e_val = egv_pkg::sat32(ident - acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sub_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			n_q         <= '0;
			l_q         <= '0;
			m_q         <= '0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && opcode == egv_pkg::OP_COMPUTE) begin
						state_q <= S_COF;
						sub_q   <= '0;
						r_q     <= '0;
						c_q     <= '0;
						n_q     <= '0;
					end else if (accept && opcode == egv_pkg::OP_READ) begin
						state_q <= S_READ;
					end
				end
				S_COF, S_DET, S_T, S_W, S_E: begin
					if (sub_q == 2'd2) begin
						if (n_last) begin
							sub_q <= 2'd3;
						end else begin
							sub_q <= '0;
							n_q   <= n_q + 1'b1;
						end
					end else if (sub_q == 2'd3) begin
						sub_q <= '0;
						n_q   <= '0;
						if (state_q == S_DET) begin
							r_q <= '0;
							c_q <= '0;
							if (acc == '0) begin
								sing_q  <= 1'b1;
								state_q <= S_RESP;
							end else begin
								sing_q  <= 1'b0;
								state_q <= S_DIV;
							end
						end else if (rc_last) begin
							r_q <= '0;
							c_q <= '0;
							case (state_q)
								S_COF: state_q <= S_DET;
								S_T:   state_q <= S_W;
								S_W:   state_q <= S_E;
								default: begin
									if (base_last) begin
										state_q <= S_RESP;
									end else begin
										state_q <= S_T;
										if (m_q == CW'(DIM - 1)) begin
											m_q <= '0;
											l_q <= l_q + 1'b1;
										end else begin
											m_q <= m_q + 1'b1;
										end
									end
								end
							endcase
						end else if (c_q == CW'(DIM - 1)) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				S_DIV: begin
					if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else if (div_done) begin
						sub_q <= '0;
						if (rc_last) begin
							r_q     <= '0;
							c_q     <= '0;
							l_q     <= '0;
							m_q     <= '0;
							state_q <= S_T;
						end else if (c_q == CW'(DIM - 1)) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				S_RESP, S_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == egv_pkg::OP_LOAD_F && element_index < 7'(MAT_N)) begin
			f_q[element_index[MI_W-1:0]] <= data_in;
		end
		if (accept && opcode == egv_pkg::OP_LOAD_FP && element_index < 7'(MAT_N)) begin
			p_q[element_index[MI_W-1:0]] <= data_in;
		end
		if (accept && opcode == egv_pkg::OP_READ) begin
			oob_q <= element_index >= 7'(TEN_N);
		end
		if (busy_ph && sub_q == 2'd0) begin
			opa_q  <= opa;
			opb_q  <= opb;
			osub_q <= osub;
		end
		if (fin) begin
			case (state_q)
				S_COF: cof_q[mi(int'(r_q), int'(c_q))] <=
					egv_pkg::sat32((r_q[0] ^ c_q[0]) ? -acc : acc);
				S_DET: det_q <= acc;
				S_T:   t_q[mi(int'(r_q), int'(c_q))] <= egv_pkg::sat32(acc);
				S_W:   w_q[mi(int'(r_q), int'(c_q))] <= egv_pkg::sat32(acc);
				default: begin
				end
			endcase
		end
		if (state_q == S_DIV && div_done) begin
			pinv_q[mi(int'(r_q), int'(c_q))] <= pinv_val;
		end
		if (state_q == S_RESP) begin
			kind_q  <= 1'b0;
			dout_q  <= '0;
			osing_q <= sing_q;
		end else if (state_q == S_READ) begin
			kind_q  <= 1'b1;
			dout_q  <= (oob_q || sing_q) ? '0 : dfe_rd_q;
			osing_q <= sing_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == egv_pkg::OP_LOAD_DFP && element_index < 7'(TEN_N)) begin
			dfp_mem[element_index[TI_W-1:0]] <= data_in;
		end
		dfp_rd_q <= dfp_mem[dfp_raddr];
	end

	always_ff @(posedge clk) begin
		if (fin && state_q == S_E) begin
			dfe_mem[dfe_waddr] <= e_val;
		end
		dfe_rd_q <= dfe_mem[dfe_raddr];
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign data_out    = dout_q;
	assign singular    = osing_q;

	a_cmp_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == egv_pkg::OP_COMPUTE |=> state_q == S_COF)
		else $error("compute request did not start the sequencer");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RESP || $past(state_q) == S_READ)
		else $error("result raised outside a response state");

	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_DIV)
		else $error("divider running outside the inverse phase");

endmodule
`default_nettype wire
